[hdl/e2q_pkg.sv]
// Package for the Euler-angle to quaternion core: formats, CORDIC constants
// and the arctangent table. No dependencies.
package e2q_pkg;

  localparam int OUT_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_X0 = 19898;
  localparam int HALF_TURN = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int SQRT_STEPS = 32;

  typedef logic signed [17:0] trig_t;
  typedef logic signed [24:0] zang_t;
  typedef logic signed [35:0] pair_t;
  typedef logic signed [53:0] trip_t;
  typedef logic signed [33:0] q_t;

  function automatic zang_t atan_val(input int i);
    zang_t r;
    case (i)
      0: r = 25'sd1474560;
      1: r = 25'sd870484;
      2: r = 25'sd459940;
      3: r = 25'sd233473;
      4: r = 25'sd117189;
      5: r = 25'sd58653;
      6: r = 25'sd29333;
      7: r = 25'sd14667;
      8: r = 25'sd7334;
      9: r = 25'sd3667;
      10: r = 25'sd1833;
      11: r = 25'sd917;
      12: r = 25'sd458;
      13: r = 25'sd229;
      14: r = 25'sd115;
      15: r = 25'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/e2q_cordic.sv]
// Half-angle wrap/fold and pipelined 16-step CORDIC giving cos and sin.
// Depends on e2q_pkg.
module e2q_cordic import e2q_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle_i,
  output trig_t              cos_o,
  output trig_t              sin_o
);

  logic signed [16:0] a_w;
  logic               neg_w;
  trig_t x_r [0:CORDIC_STEPS];
  trig_t y_r [0:CORDIC_STEPS];
  zang_t z_r [0:CORDIC_STEPS];
  logic  neg_r [0:CORDIC_STEPS];

  always_comb begin
    a_w = 17'(angle_i);
    neg_w = 1'b0;
    if (a_w >= 17'(HALF_TURN)) begin
      a_w = a_w - 17'(2 * HALF_TURN);
    end
    if (a_w < -17'(HALF_TURN)) begin
      a_w = a_w + 17'(2 * HALF_TURN);
    end
    if (a_w > 17'(QUARTER_TURN)) begin
      a_w = a_w - 17'(HALF_TURN);
      neg_w = 1'b1;
    end else if (a_w < -17'(QUARTER_TURN)) begin
      a_w = a_w + 17'(HALF_TURN);
      neg_w = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= trig_t'(CORDIC_X0);
      y_r[0] <= '0;
      z_r[0] <= zang_t'(a_w) <<< 8;
      neg_r[0] <= neg_w;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_val(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_o <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

endmodule

[hdl/e2q_div.sv]
// One normalization lane: pipelined restoring division of |part| by the norm,
// rounding, saturation and sign. Depends on e2q_pkg.
module e2q_div import e2q_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  q_t          part_i,
  input  logic [31:0] norm_i,
  output logic [15:0] quat_o
);

  localparam int QW = OUT_FRAC_BITS + 2;
  localparam int NUMW = 34 + OUT_FRAC_BITS;
  localparam int VW = (QW + 1 > 17) ? QW + 1 : 17;

  logic [33:0]     mag_w;
  logic [NUMW-1:0] num_w;

  logic [31:0]   rem_r  [0:QW];
  logic [QW-1:0] quo_r  [0:QW];
  logic [QW-1:0] lo_r   [0:QW];
  logic [31:0]   norm_r [0:QW];
  logic          ovf_r  [0:QW];
  logic          zero_r [0:QW];
  logic          neg_r  [0:QW];

  logic [QW-1:0]          qs_w;
  logic signed [VW-1:0]   v_w;
  logic [15:0]            res_w;

  always_comb begin
    mag_w = part_i[33] ? 34'(-part_i) : 34'(part_i);
    num_w = (NUMW'(mag_w) << OUT_FRAC_BITS) + NUMW'(norm_i >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num_w[NUMW-1:QW];
      lo_r[0]   <= num_w[QW-1:0];
      quo_r[0]  <= '0;
      norm_r[0] <= norm_i;
      ovf_r[0]  <= num_w[NUMW-1:QW] >= norm_i;
      zero_r[0] <= norm_i == '0;
      neg_r[0]  <= part_i[33];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [32:0] t_w;
    logic        ge_w;
    always_comb begin
      t_w = {rem_r[k], lo_r[k][QW-1-k]};
      ge_w = t_w >= {1'b0, norm_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge_w ? 32'(t_w - {1'b0, norm_r[k]}) : t_w[31:0];
        quo_r[k+1]  <= {quo_r[k][QW-2:0], ge_w};
        lo_r[k+1]   <= lo_r[k];
        norm_r[k+1] <= norm_r[k];
        ovf_r[k+1]  <= ovf_r[k];
        zero_r[k+1] <= zero_r[k];
        neg_r[k+1]  <= neg_r[k];
      end
    end
  end

  always_comb begin
    qs_w = quo_r[QW];
    if (ovf_r[QW] || (quo_r[QW] > (QW'(1) << OUT_FRAC_BITS))) begin
      qs_w = QW'(1) << OUT_FRAC_BITS;
    end
    v_w = neg_r[QW] ? -$signed(VW'(qs_w)) : $signed(VW'(qs_w));
    if (v_w > $signed(VW'(32767))) begin
      res_w = 16'h7fff;
    end else if (v_w < -$signed(VW'(32768))) begin
      res_w = 16'h8000;
    end else begin
      res_w = v_w[15:0];
    end
    if (zero_r[QW]) begin
      res_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_o <= res_w;
    end
  end

endmodule

[hdl/euler_to_quaternion_core.sv]
// Euler angles (ZYX) to normalized quaternion, fully pipelined.
// Pipe order: CORDIC, product and sum-of-squares registers, 32 square-root
// steps, then division and output.
// Throughput: one beat per cycle; the whole pipe holds while the output stalls.
// Reset (rst_n, synchronous) clears the valid bits only.
module euler_to_quaternion_core import e2q_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_deg, pitch_deg, yaw_deg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  localparam int LAT = 59 + OUT_FRAC_BITS;

  logic en;
  logic vld_r [0:LAT-1];

  trig_t cx, sx, cy, sy, cz, sz;
  pair_t czcy_r, szsy_r, czsy_r, szcy_r;
  trig_t cx1_r, sx1_r;
  trip_t p_r [0:7];
  q_t    q_w [0:3];
  q_t    q_r [0:3];
  q_t    qsq_r [0:3];
  logic [63:0] sq_r [0:3];
  logic [63:0] sq_w [0:3];
  logic [33:0] ab_w [0:3];
  logic [63:0] sv_r   [0:SQRT_STEPS];
  logic [63:0] sres_r [0:SQRT_STEPS];
  q_t    qp_r [0:SQRT_STEPS][0:3];
  logic [15:0] quat_w [0:3];

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  e2q_cordic u_roll (.clk(clk), .en(en), .angle_i(in_tdata[15:0]), .cos_o(cx), .sin_o(sx));
  e2q_cordic u_pitch (.clk(clk), .en(en), .angle_i(in_tdata[31:16]), .cos_o(cy), .sin_o(sy));
  e2q_cordic u_yaw (.clk(clk), .en(en), .angle_i(in_tdata[47:32]), .cos_o(cz), .sin_o(sz));

  always_ff @(posedge clk) begin
    if (en) begin
      czcy_r <= pair_t'(cz) * pair_t'(cy);
      szsy_r <= pair_t'(sz) * pair_t'(sy);
      czsy_r <= pair_t'(cz) * pair_t'(sy);
      szcy_r <= pair_t'(sz) * pair_t'(cy);
      cx1_r <= cx;
      sx1_r <= sx;
      p_r[0] <= trip_t'(czcy_r) * trip_t'(cx1_r);
      p_r[1] <= trip_t'(szsy_r) * trip_t'(sx1_r);
      p_r[2] <= trip_t'(czcy_r) * trip_t'(sx1_r);
      p_r[3] <= trip_t'(szsy_r) * trip_t'(cx1_r);
      p_r[4] <= trip_t'(czsy_r) * trip_t'(cx1_r);
      p_r[5] <= trip_t'(szcy_r) * trip_t'(sx1_r);
      p_r[6] <= trip_t'(szcy_r) * trip_t'(cx1_r);
      p_r[7] <= trip_t'(czsy_r) * trip_t'(sx1_r);
    end
  end

  always_comb begin
    q_w[0] = q_t'((55'(p_r[0]) + 55'(p_r[1])) >>> 15);
    q_w[1] = q_t'((55'(p_r[2]) - 55'(p_r[3])) >>> 15);
    q_w[2] = q_t'((55'(p_r[4]) + 55'(p_r[5])) >>> 15);
    q_w[3] = q_t'((55'(p_r[6]) - 55'(p_r[7])) >>> 15);
    for (int k = 0; k < 4; k++) begin
      ab_w[k] = q_r[k][33] ? 34'(-q_r[k]) : 34'(q_r[k]);
      sq_w[k] = ab_w[k][31:0] * ab_w[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q_r[k] <= q_w[k];
        qsq_r[k] <= q_r[k];
        sq_r[k] <= sq_w[k];
        qp_r[0][k] <= qsq_r[k];
      end
      sv_r[0] <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
      sres_r[0] <= '0;
    end
  end

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * s);
    logic [63:0] t_w;
    assign t_w = sres_r[s] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sv_r[s] >= t_w) begin
          sv_r[s+1] <= sv_r[s] - t_w;
          sres_r[s+1] <= (sres_r[s] >> 1) + BIT;
        end else begin
          sv_r[s+1] <= sv_r[s];
          sres_r[s+1] <= sres_r[s] >> 1;
        end
        for (int k = 0; k < 4; k++) begin
          qp_r[s+1][k] <= qp_r[s][k];
        end
      end
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    e2q_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
      .clk(clk),
      .en(en),
      .part_i(qp_r[SQRT_STEPS][k]),
      .norm_i(sres_r[SQRT_STEPS][31:0]),
      .quat_o(quat_w[k])
    );
  end

  assign out_tdata = {quat_w[3], quat_w[2], quat_w[1], quat_w[0]};

endmodule
